// File: src/ntfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfb_pkg
// Shared widths, register indexes and the result record of the
// nearest-timestamp frame buffer.
// ----------------------------------------------------------------------------
package ntfb_pkg;

  localparam int STAMP_W    = 63;
  localparam int TOL_W      = 32;
  localparam int CAP_W      = 9;
  localparam int POS_W      = 8;
  localparam int OCC_W      = 9;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CAPACITY  = 1'b1;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd50000000;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd180;

  // item operation codes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   age_position;
    logic [POS_W-1:0]   newer_entries;
    logic [STAMP_W-1:0] matched_stamp_ns;
    logic [OCC_W-1:0]   occupancy;
  } result_t;

endpackage

// File: src/ntfb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfb_store
// Stamp history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ntfb_store #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]       wr_addr,
  input  logic [ntfb_pkg::STAMP_W-1:0]           wr_data,
  input  logic                                   rd_en,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]       rd_addr,
  output logic [ntfb_pkg::STAMP_W-1:0]           rd_data
);
  import ntfb_pkg::*;

  logic [STAMP_W-1:0] mem [HISTORY_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/ntfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfb_ctrl
// Sequencer: ring pointers, push/trim, and the lookup scan over the store
// (read, absolute difference, running minimum).
// ----------------------------------------------------------------------------
module ntfb_ctrl #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // item in
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_op,
  input  logic [ntfb_pkg::STAMP_W-1:0]           in_stamp,
  // configuration
  input  logic [ntfb_pkg::TOL_W-1:0]             tolerance,
  input  logic [ntfb_pkg::CAP_W-1:0]             capacity,
  // store
  output logic                                   wr_en,
  output logic [$clog2(HISTORY_DEPTH)-1:0]       wr_addr,
  output logic [ntfb_pkg::STAMP_W-1:0]           wr_data,
  output logic                                   rd_en,
  output logic [$clog2(HISTORY_DEPTH)-1:0]       rd_addr,
  input  logic [ntfb_pkg::STAMP_W-1:0]           rd_data,
  // result
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output ntfb_pkg::result_t                      res
);
  import ntfb_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = AW + 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH, ST_TRIM, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      oldest;
  logic [CW-1:0]      count;
  logic [STAMP_W-1:0] key;
  logic [AW-1:0]      scan_pos;
  logic [AW-1:0]      scan_addr;
  // read stage and difference stage of the scan pipeline
  logic               p1_valid;
  logic [AW-1:0]      p1_pos;
  logic               p2_valid;
  logic [AW-1:0]      p2_pos;
  logic [STAMP_W-1:0] p2_diff;
  logic [STAMP_W-1:0] p2_stamp;
  // running best
  logic               best_have;
  logic [AW-1:0]      best_pos;
  logic [STAMP_W-1:0] best_diff;
  logic [STAMP_W-1:0] best_stamp;

  logic [CW-1:0]      cap_eff;
  logic               full;
  logic [SW-1:0]      tail_sum;
  logic [AW-1:0]      tail_slot;
  logic [SW-1:0]      trim_sum;
  logic [AW-1:0]      trim_slot;
  logic [CW-1:0]      drop;
  logic               scan_last;
  logic [STAMP_W-1:0] abs_diff;
  logic               take_p2;
  logic [CW-1:0]      newer;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    wrap_inc = (a == AW'(HISTORY_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  always_comb begin
    cap_eff = (32'(capacity) > 32'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : CW'(capacity);
    full    = (count == CW'(HISTORY_DEPTH));

    tail_sum = SW'(oldest) + SW'(count);
    if (tail_sum >= SW'(HISTORY_DEPTH)) begin
      tail_sum = tail_sum - SW'(HISTORY_DEPTH);
    end
    tail_slot = tail_sum[AW-1:0];

    drop     = count - cap_eff;
    trim_sum = SW'(oldest) + SW'(drop);
    if (trim_sum >= SW'(HISTORY_DEPTH)) begin
      trim_sum = trim_sum - SW'(HISTORY_DEPTH);
    end
    trim_slot = trim_sum[AW-1:0];

    scan_last = (CW'(scan_pos) + CW'(1) == count);

    abs_diff = (rd_data >= key) ? rd_data - key : key - rd_data;
    // strict less-than keeps the older entry on a tie
    take_p2  = p2_valid && (!best_have || (p2_diff < best_diff));
    newer    = count - CW'(1) - CW'(best_pos);
  end

  assign in_ready  = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // store is written only in PUSH and read only in SCAN, so accesses never overlap
  assign wr_en   = (state == ST_PUSH);
  assign wr_addr = full ? oldest : tail_slot;
  assign wr_data = key;
  assign rd_en   = (state == ST_SCAN);
  assign rd_addr = scan_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      oldest    <= '0;
      count     <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      best_have <= 1'b0;
    end else begin
      p1_valid <= (state == ST_SCAN);
      p1_pos   <= scan_pos;
      p2_valid <= p1_valid;
      p2_pos   <= p1_pos;
      p2_diff  <= abs_diff;
      p2_stamp <= rd_data;
      if (take_p2) begin
        best_have  <= 1'b1;
        best_pos   <= p2_pos;
        best_diff  <= p2_diff;
        best_stamp <= p2_stamp;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key       <= in_stamp;
            best_have <= 1'b0;
            scan_pos  <= '0;
            scan_addr <= oldest;
            if (in_op == OP_PUSH) begin
              state <= ST_PUSH;
            end else if (count == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_PUSH: begin
          if (full) begin
            oldest <= wrap_inc(oldest);
          end else begin
            count <= count + CW'(1);
          end
          state <= ST_TRIM;
        end
        ST_TRIM: begin
          if (count > cap_eff) begin
            oldest <= trim_slot;
            count  <= cap_eff;
          end
          state <= ST_DECIDE;
        end
        ST_SCAN: begin
          scan_pos  <= scan_pos + AW'(1);
          scan_addr <= wrap_inc(scan_addr);
          if (scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          // best_have is clear for a push or an empty buffer
          res.occupancy <= OCC_W'(count);
          if (best_have && (best_diff <= STAMP_W'(tolerance))) begin
            res.hit              <= 1'b1;
            res.age_position     <= POS_W'(best_pos);
            res.newer_entries    <= POS_W'(newer);
            res.matched_stamp_ns <= best_stamp;
          end else begin
            res.hit              <= 1'b0;
            res.age_position     <= '0;
            res.newer_entries    <= '0;
            res.matched_stamp_ns <= '0;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/nearest_timestamp_frame_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_buffer
// Frame timestamp history with nearest-stamp lookup within a tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_* : s_tuser is the operation (0 push, 1 look up),
//   s_tdata carries the stamp in ns. Every item yields exactly one result on
//   m_*: m_tuser is the hit flag, m_tdata carries position, newer count,
//   matched stamp and occupancy.
//   Configuration (tolerance, capacity) is written through cfg_we/cfg_addr/
//   cfg_wdata while the block is idle; a lowered capacity takes effect on
//   the next push.
//   A push passes the push and trim steps before the decision; a lookup of an
//   empty buffer goes straight to the decision; any other lookup first scans
//   the occupied entries, reading one stored stamp per cycle from the single
//   read port of the history memory, and drains the scan pipeline. One item
//   is in work at a time; the next is accepted once the controller is idle
//   again, which it becomes as the result moves into the output register.
//   The result sits in an output register; while the receiver stalls, one
//   more item can be taken and finished, then the input stalls until the
//   output register frees up.
//   Reset (synchronous, rst high) empties the buffer and restores tolerance
//   50 ms and capacity 180; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module nearest_timestamp_frame_buffer #(
  parameter int HISTORY_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [63:0]                         s_tdata,  // [62:0] stamp_ns, [63] zero
  input  logic                                s_tuser,  // [0] operation
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] age_position, [15:8] newer_entries, [78:16] matched_stamp_ns,
  // [87:79] occupancy
  output logic [87:0]                         m_tdata,
  output logic                                m_tuser,  // [0] hit
  // configuration
  input  logic                                cfg_we,
  input  logic [ntfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ntfb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ntfb_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [TOL_W-1:0]   tolerance;
  logic [CAP_W-1:0]   capacity;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [STAMP_W-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [STAMP_W-1:0] rd_data;
  logic               res_valid;
  logic               res_ready;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      capacity  <= CAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TOLERANCE: tolerance <= cfg_wdata[TOL_W-1:0];
        CFG_CAPACITY:  capacity  <= cfg_wdata[CAP_W-1:0];
        default:       ;
      endcase
    end
  end

  ntfb_store #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ntfb_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser),
    .in_stamp (s_tdata[STAMP_W-1:0]),
    .tolerance(tolerance),
    .capacity (capacity),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        m_tuser <= res.hit;
        m_tdata <= {res.occupancy, res.matched_stamp_ns,
                    res.newer_entries, res.age_position};
      end
    end
  end

`ifndef SYNTHESIS
  // one item in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in work");

  // a hit lies inside the occupied range: older + match + newer = occupancy
  a_hit_position: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (8'(m_tdata[7:0] + m_tdata[15:8] + 8'd1) == m_tdata[86:79]))
    else $error("hit position does not fit occupancy");

  // a miss or a push reports no match fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[78:0] == '0))
    else $error("match fields set without a hit");
`endif

endmodule
